### rtl/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared constants, types and helpers of the SAD stereo block matcher.
// ----------------------------------------------------------------------------
package sbm_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_WINDOW  = 15;
	localparam int MAX_DISP    = 64;

	localparam int PIX_W       = 8;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = 10;
	localparam int ROW_TOP     = 1023;
	localparam int WIN_W       = 4;
	localparam int WSZ_W       = $clog2(MAX_WINDOW + 1);
	localparam int SLOT_W      = $clog2(MAX_WINDOW);
	localparam int DISP_W      = $clog2(MAX_DISP);
	localparam int SAD_W       = 16;
	localparam int SCALE_W     = 16;
	localparam int DEPTH_W     = 8;
	localparam int DEPTH_MAX   = 255;
	localparam int STORE_DEPTH = MAX_WINDOW * MAX_WIDTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int T_W         = $clog2(MAX_WINDOW + 2 * MAX_DISP);
	localparam int CNT_W       = $clog2(SCALE_W + 1);

	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = CFG_IDX_W'(1);

	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

	function automatic logic [WSZ_W-1:0] eff_window(input logic [WIN_W-1:0] ws);
		logic [WIN_W:0] c;
		logic [WSZ_W-1:0] r;
		c = {1'b0, ws} | (WIN_W+1)'(1);
		if (c < (WIN_W+1)'(3)) begin
			c = (WIN_W+1)'(3);
		end
		if (32'(c) > MAX_WINDOW) begin
			r = WSZ_W'(MAX_WINDOW);
		end else begin
			r = WSZ_W'(c);
		end
		if (!r[0]) begin
			r = r - WSZ_W'(1);
		end
		return r;
	endfunction

endpackage

### rtl/sad_stereo_block_matcher_core.sv
// ----------------------------------------------------------------------------
// sad_stereo_block_matcher_core
// Disparity and depth from a rectified grey stereo pixel stream.
// ----------------------------------------------------------------------------
// Each pixel beat is written to the line stores in the cycle it is accepted.
// A pixel that completes no interior window leaves the core ready. One
// that does starts a match, with in_ready low: each window row is
// streamed out of the single read port of the line stores, one column a
// cycle, through a chain of 64 disparity cells; the cell sums are then
// shifted out one a cycle to find the least, and a bit-serial divider
// forms the depth. A finished result waits in the output register while
// the next beat is taken.
module sad_stereo_block_matcher_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     left_pixel,
	input  logic [7:0]                     right_pixel,
	input  logic                           end_of_row,
	input  logic                           end_of_frame,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [9:0]                     out_row,
	output logic [9:0]                     out_col,
	output logic [5:0]                     disparity,
	output logic [7:0]                     depth,
	output logic [15:0]                    best_sad,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sbm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_STREAM = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DIVS   = 3'd3;
	localparam logic [2:0] ST_DIVW   = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [sbm_pkg::WIN_W-1:0] win_cfg_q;
	logic [sbm_pkg::SCALE_W-1:0] scale_q;
	logic [sbm_pkg::COL_W-1:0] col_q, jcol_q;
	logic [sbm_pkg::ROW_W-1:0] row_q, jrow_q;
	logic [sbm_pkg::SLOT_W-1:0] ring_q, slot_q;
	logic [sbm_pkg::WSZ_W-1:0] w_q, h_q, a_q;
	logic [sbm_pkg::DISP_W-1:0] dmax_q, dscan_q, bestd_q;
	logic [sbm_pkg::T_W-1:0] t_q;
	logic [sbm_pkg::SAD_W-1:0] best_q;
	logic [sbm_pkg::SCALE_W-1:0] quo_q;
	logic tag_s1;

	logic out_valid_q;
	logic [9:0] out_row_q, out_col_q;
	logic [5:0] disp_q;
	logic [7:0] depth_q;
	logic [15:0] sad_q;

	logic in_accept, produce, last_t, out_load;
	logic [sbm_pkg::WSZ_W-1:0] w_c, h_c, two_h;
	logic [sbm_pkg::COL_W-1:0] dspan, rd_col;
	logic [sbm_pkg::DISP_W-1:0] dmax_c;
	logic [sbm_pkg::ADDR_W-1:0] waddr, raddr;
	logic rd_en;
	logic [sbm_pkg::PIX_W-1:0] rd_left, rd_right;
	sbm_pkg::cell_ctrl_t ctrl;
	logic div_start, div_done;
	logic [sbm_pkg::SCALE_W-1:0] div_quo;

	assign in_ready  = state_q == ST_IDLE;
	assign in_accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign w_c     = sbm_pkg::eff_window(win_cfg_q);
	assign h_c     = w_c >> 1;
	assign two_h   = {h_c[sbm_pkg::WSZ_W-2:0], 1'b0};
	assign produce = (row_q >= sbm_pkg::ROW_W'(two_h)) && (col_q >= sbm_pkg::COL_W'(two_h));
	assign dspan   = col_q - sbm_pkg::COL_W'(two_h);
	assign dmax_c  = (32'(dspan) > sbm_pkg::MAX_DISP - 1) ?
		sbm_pkg::DISP_W'(sbm_pkg::MAX_DISP - 1) : sbm_pkg::DISP_W'(dspan);

	assign waddr  = sbm_pkg::ADDR_W'(ring_q) * sbm_pkg::ADDR_W'(sbm_pkg::MAX_WIDTH)
		+ sbm_pkg::ADDR_W'(col_q);
	assign rd_col = jcol_q - sbm_pkg::COL_W'(t_q);
	assign raddr  = sbm_pkg::ADDR_W'(slot_q) * sbm_pkg::ADDR_W'(sbm_pkg::MAX_WIDTH)
		+ sbm_pkg::ADDR_W'(rd_col);
	assign rd_en  = state_q == ST_STREAM;
	assign last_t = t_q == (sbm_pkg::T_W'(w_q) + sbm_pkg::T_W'(2 * sbm_pkg::MAX_DISP - 1));

	assign ctrl.clear = in_accept && produce;
	assign ctrl.shift = state_q == ST_SCAN;
	assign div_start  = (state_q == ST_DIVS) && (bestd_q != '0);
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	sbm_line_store u_store (
		.clk    (clk),
		.we     (in_accept),
		.waddr  (waddr),
		.wleft  (left_pixel),
		.wright (right_pixel),
		.re     (rd_en),
		.raddr  (raddr),
		.rleft  (rd_left),
		.rright (rd_right)
	);

	logic [sbm_pkg::PIX_W-1:0] l_c [sbm_pkg::MAX_DISP];
	logic [sbm_pkg::PIX_W-1:0] r_c [sbm_pkg::MAX_DISP];
	logic                      t_c [sbm_pkg::MAX_DISP];
	logic [sbm_pkg::SAD_W-1:0] s_c [sbm_pkg::MAX_DISP];

	for (genvar k = 0; k < sbm_pkg::MAX_DISP; k++) begin : g_cell
		logic [sbm_pkg::PIX_W-1:0] l_in, r_in;
		logic t_in;
		logic [sbm_pkg::SAD_W-1:0] s_in;
		if (k == 0) begin : g_head
			assign l_in = rd_left;
			assign r_in = rd_right;
			assign t_in = tag_s1;
		end else begin : g_body
			assign l_in = l_c[k-1];
			assign r_in = r_c[k-1];
			assign t_in = t_c[k-1];
		end
		if (k == sbm_pkg::MAX_DISP - 1) begin : g_tail
			assign s_in = '0;
		end else begin : g_next
			assign s_in = s_c[k+1];
		end
		sbm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.left_in   (l_in),
			.tag_in    (t_in),
			.right_in  (r_in),
			.sum_in    (s_in),
			.left_out  (l_c[k]),
			.tag_out   (t_c[k]),
			.right_out (r_c[k]),
			.sum_out   (s_c[k])
		);
	end

	sbm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (scale_q),
		.divisor  (bestd_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_cfg_q   <= sbm_pkg::WIN_W'(3);
			scale_q     <= sbm_pkg::SCALE_W'(3000);
			col_q       <= '0;
			row_q       <= '0;
			ring_q      <= '0;
			tag_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == sbm_pkg::CFG_WINDOW) begin
					win_cfg_q <= cfg_data[sbm_pkg::WIN_W-1:0];
				end else if (cfg_index == sbm_pkg::CFG_SCALE) begin
					scale_q <= cfg_data[sbm_pkg::SCALE_W-1:0];
				end
			end

			tag_s1 <= rd_en && (t_q < sbm_pkg::T_W'(w_q));

			if (in_accept) begin
				if (end_of_frame) begin
					col_q  <= '0;
					row_q  <= '0;
					ring_q <= '0;
				end else if (end_of_row) begin
					col_q <= '0;
					if (row_q < sbm_pkg::ROW_W'(sbm_pkg::ROW_TOP)) begin
						row_q <= row_q + sbm_pkg::ROW_W'(1);
					end
					if (ring_q == sbm_pkg::SLOT_W'(sbm_pkg::MAX_WINDOW - 1)) begin
						ring_q <= '0;
					end else begin
						ring_q <= ring_q + sbm_pkg::SLOT_W'(1);
					end
				end else if (col_q < sbm_pkg::COL_W'(sbm_pkg::MAX_WIDTH - 1)) begin
					col_q <= col_q + sbm_pkg::COL_W'(1);
				end
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_accept && produce) begin
						state_q <= ST_STREAM;
					end
				end
				ST_STREAM: begin
					if (last_t && (a_q == w_q - sbm_pkg::WSZ_W'(1))) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (dscan_q == dmax_q) begin
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					if (bestd_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				jcol_q  <= col_q;
				jrow_q  <= row_q;
				slot_q  <= ring_q;
				w_q     <= w_c;
				h_q     <= h_c;
				dmax_q  <= dmax_c;
				t_q     <= '0;
				a_q     <= '0;
				dscan_q <= '0;
			end
			ST_STREAM: begin
				if (last_t) begin
					t_q <= '0;
					a_q <= a_q + sbm_pkg::WSZ_W'(1);
					if (slot_q == '0) begin
						slot_q <= sbm_pkg::SLOT_W'(sbm_pkg::MAX_WINDOW - 1);
					end else begin
						slot_q <= slot_q - sbm_pkg::SLOT_W'(1);
					end
				end else begin
					t_q <= t_q + sbm_pkg::T_W'(1);
				end
			end
			ST_SCAN: begin
				if ((dscan_q == '0) || (s_c[0] <= best_q)) begin
					best_q  <= s_c[0];
					bestd_q <= dscan_q;
				end
				dscan_q <= dscan_q + sbm_pkg::DISP_W'(1);
			end
			ST_DIVS: begin
				quo_q <= scale_q;
			end
			ST_DIVW: begin
				if (div_done) begin
					quo_q <= div_quo;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					out_row_q <= 10'(jrow_q - sbm_pkg::ROW_W'(h_q));
					out_col_q <= 10'(jcol_q - sbm_pkg::COL_W'(h_q));
					disp_q    <= 6'(bestd_q);
					depth_q   <= (32'(quo_q) > sbm_pkg::DEPTH_MAX) ?
						8'(sbm_pkg::DEPTH_MAX) : 8'(quo_q);
					sad_q     <= 16'(best_q);
				end
			end
			default: begin
				t_q <= '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign disparity = disp_q;
	assign depth     = depth_q;
	assign best_sad  = sad_q;

endmodule

### rtl/sbm_cell.sv
// ----------------------------------------------------------------------------
// sbm_cell
// One disparity cell: passes the left stream through two registers and the
// right stream through one, accumulates the absolute difference of tagged
// pairs, and shifts its sum toward the head of the chain when asked.
// ----------------------------------------------------------------------------
module sbm_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sbm_pkg::cell_ctrl_t      ctrl,
	input  logic [sbm_pkg::PIX_W-1:0] left_in,
	input  logic                     tag_in,
	input  logic [sbm_pkg::PIX_W-1:0] right_in,
	input  logic [sbm_pkg::SAD_W-1:0] sum_in,
	output logic [sbm_pkg::PIX_W-1:0] left_out,
	output logic                     tag_out,
	output logic [sbm_pkg::PIX_W-1:0] right_out,
	output logic [sbm_pkg::SAD_W-1:0] sum_out
);

	logic [sbm_pkg::PIX_W-1:0] l_a_q, l_b_q, r_a_q;
	logic t_a_q, t_b_q;
	logic [sbm_pkg::SAD_W-1:0] sum_q;
	logic [sbm_pkg::PIX_W-1:0] diff;

	assign diff = (left_in > right_in) ? (left_in - right_in) : (right_in - left_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_a_q <= 1'b0;
			t_b_q <= 1'b0;
		end else begin
			t_a_q <= tag_in;
			t_b_q <= t_a_q;
		end
	end

	always_ff @(posedge clk) begin
		l_a_q <= left_in;
		l_b_q <= l_a_q;
		r_a_q <= right_in;
		if (ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.shift) begin
			sum_q <= sum_in;
		end else if (tag_in) begin
			sum_q <= sum_q + sbm_pkg::SAD_W'(diff);
		end
	end

	assign left_out  = l_b_q;
	assign tag_out   = t_b_q;
	assign right_out = r_a_q;
	assign sum_out   = sum_q;

endmodule

### rtl/sbm_line_store.sv
// ----------------------------------------------------------------------------
// sbm_line_store
// Ring line stores of the left and right images, one write and one read
// port each, read data registered.
// ----------------------------------------------------------------------------
module sbm_line_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [sbm_pkg::ADDR_W-1:0] waddr,
	input  logic [sbm_pkg::PIX_W-1:0]  wleft,
	input  logic [sbm_pkg::PIX_W-1:0]  wright,
	input  logic                       re,
	input  logic [sbm_pkg::ADDR_W-1:0] raddr,
	output logic [sbm_pkg::PIX_W-1:0]  rleft,
	output logic [sbm_pkg::PIX_W-1:0]  rright
);

	logic [sbm_pkg::PIX_W-1:0] left_mem  [sbm_pkg::STORE_DEPTH];
	logic [sbm_pkg::PIX_W-1:0] right_mem [sbm_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			left_mem[waddr]  <= wleft;
			right_mem[waddr] <= wright;
		end
		if (re) begin
			rleft  <= left_mem[raddr];
			rright <= right_mem[raddr];
		end
	end

endmodule

### rtl/sbm_divider.sv
// ----------------------------------------------------------------------------
// sbm_divider
// Restoring divider, one quotient bit per cycle, for the depth value.
// ----------------------------------------------------------------------------
module sbm_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sbm_pkg::SCALE_W-1:0] dividend,
	input  logic [sbm_pkg::DISP_W-1:0]  divisor,
	output logic                        done,
	output logic [sbm_pkg::SCALE_W-1:0] quotient
);

	logic busy_q, done_q;
	logic [sbm_pkg::CNT_W-1:0] cnt_q;
	logic [sbm_pkg::SCALE_W-1:0] num_q, quo_q;
	logic [sbm_pkg::DISP_W-1:0] rem_q, div_q;
	logic [sbm_pkg::DISP_W:0] trial;
	logic fits;

	assign trial = {rem_q, num_q[sbm_pkg::SCALE_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + sbm_pkg::CNT_W'(1);
				if (cnt_q == sbm_pkg::CNT_W'(sbm_pkg::SCALE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[sbm_pkg::SCALE_W-2:0], 1'b0};
			quo_q <= {quo_q[sbm_pkg::SCALE_W-2:0], fits};
			if (fits) begin
				rem_q <= sbm_pkg::DISP_W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= sbm_pkg::DISP_W'(trial);
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
